// File: hdl/tet_pkg.sv
// Shared types and constants for the timeout event table.
package tet_pkg;

	localparam int ID_W    = 8;
	localparam int TICK_W  = 32;
	localparam int DEPTH_W = 4;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 4'd15;

	typedef enum logic [1:0] {
		MODE_SET   = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SET_RD,
		ST_SET_CHK,
		ST_TICK_RD,
		ST_TICK_CHK,
		ST_FIRE_RD,
		ST_FIRE_OUT,
		ST_DONE_OUT,
		ST_ACK_OUT
	} state_t;

	typedef struct packed {
		logic  latch;
		logic  prev_load;
		logic  clear_all;
		logic  idx_clr;
		logic  idx_inc;
		logic  set_write;
		logic  tick_step;
		logic  out_load;
		kind_t out_kind;
	} tet_cmd_t;

	typedef struct packed {
		logic id_zero;
		logic el_zero;
		logic hit;
		logic fire_cur;
		logic idx_last;
		logic out_free;
	} tet_sts_t;

endpackage

// File: hdl/timeout_event_table.sv
// Timeout event table: SLOTS timer slots with set, tick and clear operations.
//
// Items enter on the item channel (item_valid/item_ready): mode, handler_id,
// timeout_ticks, tick_now. Results leave on the result channel
// (result_valid/result_ready), one per transfer, the final one with last set.
// One item is worked on at a time; the next is taken once the last result of
// the current one sits in the result register, even if it is not yet taken.
// Slots are scanned one at a time through the single-port memories:
//   set timeout: scan up to the ack (first free or same-id slot)
//   clear all / id zero / unused mode: the ack comes straight from idle
//   tick reading: an update pass over all slots, then an emit pass, one
//   fired result per expired slot, then the done result.
//   An unchanged tick reading gives its done result without a scan.
// Every result carries the occupied depth after the whole item, saturated at 15.
// A stalled receiver holds the sequencer in its emit state; nothing is lost.
// Reset empties all slots (valid flags) and zeroes the previous tick reading.
module timeout_event_table #(
	parameter int SLOTS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [1:0]                   mode,
	input  logic [tet_pkg::ID_W-1:0]     handler_id,
	input  logic [tet_pkg::TICK_W-1:0]   timeout_ticks,
	input  logic [tet_pkg::TICK_W-1:0]   tick_now,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   kind,
	output logic [tet_pkg::ID_W-1:0]     fired_id,
	output logic                         accepted,
	output logic [tet_pkg::TICK_W-1:0]   elapsed,
	output logic [tet_pkg::DEPTH_W-1:0]  depth,
	output logic                         last
);

	tet_pkg::tet_cmd_t cmd;
	tet_pkg::tet_sts_t sts;
	tet_pkg::kind_t    kind_int;

	tet_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.mode       (mode),
		.sts        (sts),
		.cmd        (cmd)
	);

	tet_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.handler_id    (handler_id),
		.timeout_ticks (timeout_ticks),
		.tick_now      (tick_now),
		.result_ready  (result_ready),
		.result_valid  (result_valid),
		.kind          (kind_int),
		.fired_id      (fired_id),
		.accepted      (accepted),
		.elapsed       (elapsed),
		.depth         (depth),
		.last          (last)
	);

	assign kind = kind_int;

`ifndef NO_ASSERTIONS
	// one item in flight: a transfer in closes the input until its last result is in the result register
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item taken while another is in flight");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(depth) <= SLOTS))
		else $error("depth beyond slot count");

	a_fired_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind == tet_pkg::KIND_FIRED) |-> !last && (fired_id != '0))
		else $error("fired result malformed");

	a_closing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (kind != tet_pkg::KIND_FIRED) |-> last)
		else $error("ack or done result without last");
`endif

endmodule

// File: hdl/tet_datapath.sv
// Slot storage, scan index, tick bookkeeping and result register.
module tet_datapath #(
	parameter int SLOTS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tet_pkg::tet_cmd_t                   cmd,
	output tet_pkg::tet_sts_t                   sts,
	input  logic [tet_pkg::ID_W-1:0]            handler_id,
	input  logic [tet_pkg::TICK_W-1:0]          timeout_ticks,
	input  logic [tet_pkg::TICK_W-1:0]          tick_now,
	input  logic                                result_ready,
	output logic                                result_valid,
	output tet_pkg::kind_t                      kind,
	output logic [tet_pkg::ID_W-1:0]            fired_id,
	output logic                                accepted,
	output logic [tet_pkg::TICK_W-1:0]          elapsed,
	output logic [tet_pkg::DEPTH_W-1:0]         depth,
	output logic                                last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	logic [tet_pkg::ID_W-1:0]   mem_id  [SLOTS];
	logic [tet_pkg::TICK_W-1:0] mem_rem [SLOTS];
	logic [tet_pkg::ID_W-1:0]   rd_id_q;
	logic [tet_pkg::TICK_W-1:0] rd_rem_q;

	logic [SLOTS-1:0]           valid_q;
	logic [SLOTS-1:0]           fire_q;
	logic [CW-1:0]              count_q;
	logic [tet_pkg::TICK_W-1:0] prev_tick_q;
	logic [IW-1:0]              idx_q;
	logic                       acc_q;
	logic [tet_pkg::ID_W-1:0]   id_q;
	logic [tet_pkg::TICK_W-1:0] timeout_q;
	logic [tet_pkg::TICK_W-1:0] elapsed_q;

	logic                       out_valid_q;
	tet_pkg::kind_t             kind_q;
	logic [tet_pkg::ID_W-1:0]   fired_id_q;
	logic                       accepted_q;
	logic [tet_pkg::TICK_W-1:0] elapsed_out_q;
	logic [tet_pkg::DEPTH_W-1:0] depth_q;
	logic                       last_q;

	logic [tet_pkg::TICK_W-1:0] elapsed_in;
	logic                       expire;
	logic                       drop;
	logic [31:0]                count_w;
	logic [tet_pkg::DEPTH_W-1:0] depth_sat;

	// modular difference: wrap of the free-running counter comes for free
	assign elapsed_in = tick_now - prev_tick_q;
	assign expire     = (rd_rem_q <= elapsed_q);
	assign drop       = cmd.tick_step && valid_q[idx_q] && expire;
	assign count_w    = 32'(count_q);
	assign depth_sat  = (count_w > 32'(tet_pkg::DEPTH_MAX)) ? tet_pkg::DEPTH_MAX
		: count_w[tet_pkg::DEPTH_W-1:0];

	always_comb begin
		sts.id_zero  = (handler_id == '0);
		sts.el_zero  = (elapsed_in == '0);
		sts.hit      = !valid_q[idx_q] || (rd_id_q == id_q);
		sts.fire_cur = fire_q[idx_q];
		sts.idx_last = (idx_q == IW'(SLOTS - 1));
		sts.out_free = !out_valid_q || result_ready;
	end

	// slot memories, read data registered; empty slots are masked by valid_q
	always_ff @(posedge clk) begin
		rd_id_q  <= mem_id[idx_q];
		rd_rem_q <= mem_rem[idx_q];
		if (cmd.set_write) begin
			mem_id[idx_q]  <= id_q;
			mem_rem[idx_q] <= timeout_q;
		end else if (cmd.tick_step && valid_q[idx_q] && !expire) begin
			mem_rem[idx_q] <= rd_rem_q - elapsed_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			id_q      <= handler_id;
			timeout_q <= timeout_ticks;
			elapsed_q <= elapsed_in;
		end
		if (cmd.out_load) begin
			kind_q        <= cmd.out_kind;
			fired_id_q    <= (cmd.out_kind == tet_pkg::KIND_FIRED) ? rd_id_q : '0;
			accepted_q    <= (cmd.out_kind == tet_pkg::KIND_ACK) ? acc_q : 1'b0;
			elapsed_out_q <= (cmd.out_kind == tet_pkg::KIND_DONE) ? elapsed_q : '0;
			depth_q       <= depth_sat;
			last_q        <= (cmd.out_kind != tet_pkg::KIND_FIRED);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fire_q      <= '0;
			count_q     <= '0;
			prev_tick_q <= '0;
			idx_q       <= '0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				fire_q <= '0;
				acc_q  <= 1'b0;
			end
			if (cmd.prev_load)
				prev_tick_q <= tick_now;
			if (cmd.clear_all) begin
				valid_q <= '0;
				count_q <= '0;
			end
			if (cmd.set_write) begin
				valid_q[idx_q] <= 1'b1;
				acc_q          <= 1'b1;
				if (!valid_q[idx_q])
					count_q <= count_q + CW'(1);
			end
			if (drop) begin
				valid_q[idx_q] <= 1'b0;
				fire_q[idx_q]  <= 1'b1;
				count_q        <= count_q - CW'(1);
			end
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + IW'(1);
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign fired_id     = fired_id_q;
	assign accepted     = accepted_q;
	assign elapsed      = elapsed_out_q;
	assign depth        = depth_q;
	assign last         = last_q;

endmodule

// File: hdl/tet_ctrl.sv
// Sequencer for set, tick and clear operations of the timeout event table.
module tet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        mode,
	input  tet_pkg::tet_sts_t sts,
	output tet_pkg::tet_cmd_t cmd
);

	tet_pkg::state_t state_q;
	tet_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tet_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				if (item_valid) begin
					case (mode)
						tet_pkg::MODE_SET:
							state_d = sts.id_zero ? tet_pkg::ST_ACK_OUT : tet_pkg::ST_SET_RD;
						tet_pkg::MODE_TICK:
							state_d = sts.el_zero ? tet_pkg::ST_DONE_OUT : tet_pkg::ST_TICK_RD;
						default:
							state_d = tet_pkg::ST_ACK_OUT;
					endcase
				end
			end
			tet_pkg::ST_SET_RD:  state_d = tet_pkg::ST_SET_CHK;
			tet_pkg::ST_SET_CHK: begin
				if (sts.hit || sts.idx_last)
					state_d = tet_pkg::ST_ACK_OUT;
				else
					state_d = tet_pkg::ST_SET_RD;
			end
			tet_pkg::ST_TICK_RD: state_d = tet_pkg::ST_TICK_CHK;
			tet_pkg::ST_TICK_CHK: begin
				state_d = sts.idx_last ? tet_pkg::ST_FIRE_RD : tet_pkg::ST_TICK_RD;
			end
			tet_pkg::ST_FIRE_RD: begin
				if (sts.fire_cur)
					state_d = tet_pkg::ST_FIRE_OUT;
				else if (sts.idx_last)
					state_d = tet_pkg::ST_DONE_OUT;
			end
			tet_pkg::ST_FIRE_OUT: begin
				if (sts.out_free)
					state_d = sts.idx_last ? tet_pkg::ST_DONE_OUT : tet_pkg::ST_FIRE_RD;
			end
			tet_pkg::ST_DONE_OUT, tet_pkg::ST_ACK_OUT: begin
				if (sts.out_free)
					state_d = tet_pkg::ST_IDLE;
			end
			default: state_d = tet_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.out_kind = tet_pkg::KIND_ACK;
		item_ready   = 1'b0;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.latch     = 1'b1;
					cmd.idx_clr   = 1'b1;
					cmd.prev_load = (mode == tet_pkg::MODE_TICK);
					cmd.clear_all = (mode == tet_pkg::MODE_CLEAR);
				end
			end
			tet_pkg::ST_SET_CHK: begin
				if (sts.hit)
					cmd.set_write = 1'b1;
				else if (!sts.idx_last)
					cmd.idx_inc = 1'b1;
			end
			tet_pkg::ST_TICK_CHK: begin
				cmd.tick_step = 1'b1;
				if (sts.idx_last)
					cmd.idx_clr = 1'b1;
				else
					cmd.idx_inc = 1'b1;
			end
			tet_pkg::ST_FIRE_RD: begin
				if (!sts.fire_cur && !sts.idx_last)
					cmd.idx_inc = 1'b1;
			end
			tet_pkg::ST_FIRE_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = tet_pkg::KIND_FIRED;
					cmd.idx_inc  = !sts.idx_last;
				end
			end
			tet_pkg::ST_DONE_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = tet_pkg::KIND_DONE;
				end
			end
			tet_pkg::ST_ACK_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = tet_pkg::KIND_ACK;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule
